// ===== design/bgns_pkg.sv =====
// Shared types and constants for the binary grid neighbor smoothing block.
`default_nettype none
package bgns_pkg;

   localparam int ROW_WIDTH   = 64;
   localparam int CFG_WIDTH   = 7;
   localparam int COUNT_WIDTH = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   // Window count thresholds and the border kept out of smoothing.
   localparam logic [COUNT_WIDTH-1:0] SET_ABOVE   = 4'd7;
   localparam logic [COUNT_WIDTH-1:0] CLEAR_BELOW = 4'd4;
   localparam int                     EDGE_MARGIN = 2;

   localparam logic [CFG_WIDTH-1:0] GRID_WIDTH_RESET = 7'd64;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] row_cells;
      logic                 last_row;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] out_cells;
      logic                 out_last;
   } rsp_payload_type;

   // New cell value as a function of the updated left neighbor.
   typedef struct packed {
      logic f0;
      logic f1;
   } lane_fn_type;

endpackage
`default_nettype wire

// ===== design/bgns_lane.sv =====
// One column lane: counts the window and gives the cell's rule against its left neighbor.
`default_nettype none
module bgns_lane (
   input  wire logic [2:0]           win_above,
   input  wire logic [1:0]           win_cur,
   input  wire logic [2:0]           win_below,
   input  wire logic                 active,
   output bgns_pkg::lane_fn_type     fn
);

   logic [bgns_pkg::COUNT_WIDTH-1:0] base;
   logic [bgns_pkg::COUNT_WIDTH-1:0] base_plus;

   function automatic logic decide(input logic [bgns_pkg::COUNT_WIDTH-1:0] cnt,
                                   input logic keep);
      logic res;
      if (cnt > bgns_pkg::SET_ABOVE) begin
         res = 1'b1;
      end else if (cnt < bgns_pkg::CLEAR_BELOW) begin
         res = 1'b0;
      end else begin
         res = keep;
      end
      return res;
   endfunction

   always_comb begin
      base = 4'(win_above[0]) + 4'(win_above[1]) + 4'(win_above[2])
           + 4'(win_cur[0])   + 4'(win_cur[1])
           + 4'(win_below[0]) + 4'(win_below[1]) + 4'(win_below[2]);
      base_plus = base + 4'd1;
      if (active) begin
         fn.f0 = decide(base, win_cur[0]);
         fn.f1 = decide(base_plus, win_cur[0]);
      end else begin
         fn.f0 = win_cur[0];
         fn.f1 = win_cur[0];
      end
   end

endmodule
`default_nettype wire

// ===== design/bgns_merge.sv =====
// Prefix composition of the lane rules into the finished left-to-right row.
`default_nettype none
module bgns_merge #(
   parameter int LANES = 64
) (
   input  wire bgns_pkg::lane_fn_type fn [LANES],
   output logic [LANES-1:0]           smoothed_row
);

   localparam int LEVELS = $clog2(LANES);

   logic [LANES-1:0] g0 [0:LEVELS];
   logic [LANES-1:0] g1 [0:LEVELS];

   genvar lv, j;
   generate
      for (j = 0; j < LANES; j++) begin : g_init
         assign g0[0][j] = fn[j].f0;
         assign g1[0][j] = fn[j].f1;
      end
      for (lv = 0; lv < LEVELS; lv++) begin : g_level
         localparam int DIST = 1 << lv;
         for (j = 0; j < LANES; j++) begin : g_col
            if (j >= DIST) begin : g_comb
               // Apply the earlier span first, then this one.
               assign g0[lv+1][j] = g0[lv][j-DIST] ? g1[lv][j] : g0[lv][j];
               assign g1[lv+1][j] = g1[lv][j-DIST] ? g1[lv][j] : g0[lv][j];
            end else begin : g_pass
               assign g0[lv+1][j] = g0[lv][j];
               assign g1[lv+1][j] = g1[lv][j];
            end
         end
      end
   endgenerate

   // The leftmost cell is never smoothed, so the chain input is irrelevant.
   assign smoothed_row = g0[LEVELS];

endmodule
`default_nettype wire

// ===== design/bgns_out_queue.sv =====
// Result queue: takes up to two rows per transaction, hands out one per cycle unless stalled.
`default_nettype none
module bgns_out_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [1:0]                push_count,
   input  wire bgns_pkg::rsp_payload_type push_first,
   input  wire bgns_pkg::rsp_payload_type push_second,
   output logic                           room_ok,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output bgns_pkg::rsp_payload_type      rsp_payload
);

   bgns_pkg::rsp_payload_type              entry_ff [bgns_pkg::QUEUE_DEPTH];
   logic [bgns_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bgns_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bgns_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic [bgns_pkg::QUEUE_PTR_W-1:0]       wr_next;
   logic                                   pop;

   always_comb begin
      pop       = rsp_valid && !rsp_stall;
      wr_next   = wr_ptr_ff + 2'd1;
      wr_ptr_in = wr_ptr_ff + push_count;
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(push_count) - 3'(pop);
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign room_ok     = (count_ff <= 3'(bgns_pkg::QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push_second;
      end
   end

endmodule
`default_nettype wire

// ===== design/binary_grid_neighbor_smoothing.sv =====
// Top level: one in-place smoothing pass over a binary grid, one row per transaction.
// Results enter a four-entry queue when their causing transaction is accepted; req_stall
//   rises while fewer than two entries are free. Throughput: one row per cycle if unstalled;
//   the whole row is smoothed combinationally by a lane per column and a prefix merge.
//   A final row with a held row yields two results, drained one per cycle if unstalled.
// Reset: synchronous; clears the grid progress and the queue, and sets grid_width to 64.
`default_nettype none
module binary_grid_neighbor_smoothing #(
   parameter int MAX_WIDTH = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire bgns_pkg::req_payload_type          req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output bgns_pkg::rsp_payload_type               rsp_payload,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bgns_pkg::CFG_WIDTH-1:0]     csr_data
);

   localparam int LANES = MAX_WIDTH;
   localparam logic [bgns_pkg::CFG_WIDTH-1:0] MaxW = bgns_pkg::CFG_WIDTH'(MAX_WIDTH);

   logic [bgns_pkg::CFG_WIDTH-1:0] grid_width_ff;
   logic [LANES-1:0]               finished_above_ff, finished_above_in;
   logic [LANES-1:0]               pending_row_ff, pending_row_in;
   logic                           pending_valid_ff, pending_valid_in;
   logic [1:0]                     rows_emitted_ff, rows_emitted_in;

   logic [bgns_pkg::CFG_WIDTH-1:0] w_eff;
   logic [LANES-1:0]               mask;
   logic [LANES-1:0]               active;
   logic [LANES-1:0]               row_in;
   logic [LANES-1:0]               pend_m;
   logic [LANES-1:0]               above_m;
   logic [LANES+1:0]               above_ext, cur_ext, below_ext;
   logic [LANES-1:0]               smoothed_row;
   logic [LANES-1:0]               done_row;
   logic                           accept;
   logic                           last;
   logic                           smooth_go;
   logic                           room_ok;
   logic [1:0]                     push_count;
   bgns_pkg::rsp_payload_type      push_first, push_second, held_out, last_out;
   bgns_pkg::lane_fn_type          fn [LANES];

   assign csr_ready = 1'b1;
   assign req_stall = !room_ok;
   assign accept    = req_valid && !req_stall;
   assign last      = req_payload.last_row;

   assign w_eff     = (grid_width_ff > MaxW) ? MaxW : grid_width_ff;

   genvar j;
   generate
      for (j = 0; j < LANES; j++) begin : g_col
         assign mask[j]   = (8'(j) < {1'b0, w_eff});
         assign active[j] = (j >= bgns_pkg::EDGE_MARGIN)
                         && (8'(j) + 8'(bgns_pkg::EDGE_MARGIN) < {1'b0, w_eff});
         bgns_lane u_lane (
            .win_above (above_ext[j+2:j]),
            .win_cur   (cur_ext[j+2:j+1]),
            .win_below (below_ext[j+2:j]),
            .active    (active[j]),
            .fn        (fn[j])
         );
      end
   endgenerate

   bgns_merge #(
      .LANES (LANES)
   ) u_merge (
      .fn           (fn),
      .smoothed_row (smoothed_row)
   );

   always_comb begin
      row_in    = req_payload.row_cells[LANES-1:0] & mask;
      pend_m    = pending_row_ff & mask;
      above_m   = finished_above_ff & mask;
      above_ext = {1'b0, above_m, 1'b0};
      cur_ext   = {1'b0, pend_m, 1'b0};
      below_ext = {1'b0, row_in, 1'b0};

      smooth_go = pending_valid_ff && !last && rows_emitted_ff[1];
      done_row  = (smooth_go ? smoothed_row : pend_m) & mask;

      held_out.out_cells = bgns_pkg::ROW_WIDTH'(done_row);
      held_out.out_last  = 1'b0;
      last_out.out_cells = bgns_pkg::ROW_WIDTH'(row_in);
      last_out.out_last  = 1'b1;

      push_first  = pending_valid_ff ? held_out : last_out;
      push_second = last_out;
      push_count  = accept ? (2'(pending_valid_ff) + 2'(last)) : 2'd0;

      finished_above_in = finished_above_ff;
      pending_row_in    = pending_row_ff;
      pending_valid_in  = pending_valid_ff;
      rows_emitted_in   = rows_emitted_ff;
      if (accept) begin
         if (last) begin
            // End of grid: start over with the next row.
            pending_valid_in = 1'b0;
            rows_emitted_in  = 2'd0;
         end else begin
            pending_row_in   = row_in;
            pending_valid_in = 1'b1;
            if (pending_valid_ff) begin
               finished_above_in = done_row;
               if (rows_emitted_ff != 2'd3) begin
                  rows_emitted_in = rows_emitted_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff    <= bgns_pkg::GRID_WIDTH_RESET;
         pending_valid_ff <= 1'b0;
         rows_emitted_ff  <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            grid_width_ff <= csr_data;
         end
         pending_valid_ff <= pending_valid_in;
         rows_emitted_ff  <= rows_emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      finished_above_ff <= finished_above_in;
      pending_row_ff    <= pending_row_in;
   end

   bgns_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (push_first),
      .push_second (push_second),
      .room_ok     (room_ok),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== tb/sv/bgns_row_checker.sv =====
// Row checker: predicts each smoothed output row and compares it with the block's output.
module bgns_row_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  bgns_pkg::req_payload_type  req_payload,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  bgns_pkg::rsp_payload_type  rsp_payload,
   input  wire logic                  csr_valid,
   input  wire logic                  csr_ready,
   input  wire logic [bgns_pkg::CFG_WIDTH-1:0] csr_data,
   output int                         outstanding,
   output int                         fail_count,
   output int                         rows_checked
);
   import bgns_pkg::*;

   localparam int GRID_MAX = 64;

   logic [CFG_WIDTH-1:0] grid_width;
   logic [ROW_WIDTH-1:0] finished_above;
   logic [ROW_WIDTH-1:0] held_row;
   logic                 held_valid;
   logic [1:0]           rows_emitted;
   rsp_payload_type      expected_rows[$];
   int                   mismatches = 0;
   int                   checked = 0;

   assign fail_count   = mismatches;
   assign rows_checked = checked;

   function automatic int active_width(logic [CFG_WIDTH-1:0] w);
      return (int'(w) > GRID_MAX) ? GRID_MAX : int'(w);
   endfunction

   function automatic logic [ROW_WIDTH-1:0] cell_mask(int w);
      if (w >= ROW_WIDTH) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   // Left neighbor is already updated; center, right and the row below are original.
   function automatic logic [ROW_WIDTH-1:0] smooth_interior(logic [ROW_WIDTH-1:0] above,
                                                           logic [ROW_WIDTH-1:0] cur,
                                                           logic [ROW_WIDTH-1:0] below,
                                                           int w);
      logic [ROW_WIDTH-1:0] row;
      int                   cnt;
      row = cur;
      for (int j = EDGE_MARGIN; j + EDGE_MARGIN < w; j++) begin
         cnt = 0;
         for (int k = -1; k <= 1; k++)
            cnt += int'(above[j+k]) + int'(row[j+k]) + int'(below[j+k]);
         if (cnt > 7) row[j] = 1'b1;
         if (cnt < 4) row[j] = 1'b0;
      end
      return row;
   endfunction

   task automatic clear_grid();
      finished_above = '0;
      held_row       = '0;
      held_valid     = 1'b0;
      rows_emitted   = '0;
   endtask

   task automatic predict_rows(input req_payload_type item);
      int                   w;
      logic [ROW_WIDTH-1:0] mask;
      logic [ROW_WIDTH-1:0] row;
      logic [ROW_WIDTH-1:0] done;
      rsp_payload_type      res;
      w    = active_width(grid_width);
      mask = cell_mask(w);
      row  = item.row_cells & mask;
      if (held_valid) begin
         done = held_row & mask;
         if (!item.last_row && rows_emitted >= 2)
            done = smooth_interior(finished_above & mask, done, row, w);
         res.out_cells = done & mask;
         res.out_last  = 1'b0;
         expected_rows = {expected_rows, res};
         finished_above = done & mask;
         if (rows_emitted < 3) rows_emitted++;
      end
      if (item.last_row) begin
         res.out_cells = row;
         res.out_last  = 1'b1;
         expected_rows = {expected_rows, res};
         clear_grid();
      end else begin
         held_row   = row;
         held_valid = 1'b1;
      end
   endtask

   task automatic report_mismatch(string what, logic [ROW_WIDTH-1:0] want,
                                  logic [ROW_WIDTH-1:0] got);
      $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      if (reset) begin
         grid_width = GRID_WIDTH_RESET;
         clear_grid();
         expected_rows.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               report_mismatch("row with none expected", '0, rsp_payload.out_cells);
            end else begin
               want = expected_rows.pop_front();
               if (rsp_payload.out_cells !== want.out_cells)
                  report_mismatch("out_cells", want.out_cells, rsp_payload.out_cells);
               if (rsp_payload.out_last !== want.out_last)
                  report_mismatch("out_last", 64'(want.out_last), 64'(rsp_payload.out_last));
               checked++;
            end
         end
         if (csr_valid && csr_ready) grid_width = csr_data;
         if (req_valid && !req_stall) predict_rows(req_payload);
      end
      outstanding <= expected_rows.size();
   end

endmodule

// ===== tb/sv/binary_grid_neighbor_smoothing_tb.sv =====
// Testbench top: drives grid rows, width writes and output back-pressure, and gives the verdict.
module binary_grid_neighbor_smoothing_tb;
   import bgns_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD  = 60;
   localparam int SETTLE     = 4;
   localparam int PHASE_ROWS = 48;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_payload_type      req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CFG_WIDTH-1:0] csr_data;

   int outstanding;
   int fail_count;
   int rows_checked;
   int rows_sent = 0;
   int widths_used = 0;
   int long_holds = 0;
   int idle_run = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   binary_grid_neighbor_smoothing uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   bgns_row_checker row_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .outstanding  (outstanding),
      .fail_count   (fail_count),
      .rows_checked (rows_checked)
   );

   always #10 clock = ~clock;

   // Abort when no transaction moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
         if (idle_run >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Output side: random stall before each result, plus long holds on request.
   initial begin : drain
      int n;
      forever begin
         if (hold_request) begin
            n = LONG_HOLD;
            hold_request = 1'b0;
            long_holds++;
         end else begin
            n = quiet ? 0 : $urandom_range(0, 14);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   function automatic logic [ROW_WIDTH-1:0] make_row(int density);
      logic [ROW_WIDTH-1:0] a;
      logic [ROW_WIDTH-1:0] b;
      logic [ROW_WIDTH-1:0] c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) density = $urandom_range(0, 5);
      case (density)
         0:       return '1;
         1:       return '0;
         2:       return a;
         3:       return a | b;
         4:       return a & b;
         default: return a | b | c;
      endcase
   endfunction

   task automatic send_row(logic [ROW_WIDTH-1:0] cells, logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{row_cells: cells, last_row: last};
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      rows_sent++;
   endtask

   // Hold the input until every expected row is out, then let the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_width(logic [CFG_WIDTH-1:0] w);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= w;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      csr_valid <= 1'b0;
      widths_used++;
   endtask

   task automatic send_grid(int rows, int density, bit noisy);
      for (int r = 0; r < rows; r++)
         send_row(make_row(density), noisy ? 1'($urandom_range(0, 1)) : (r == rows - 1));
   endtask

   initial begin : stimulus
      logic [CFG_WIDTH-1:0] phase_widths[12];
      int                   in_phase;
      int                   rows;
      phase_widths = '{7'd1, 7'd2, 7'd64, 7'd5, 7'd6, 7'd8, 7'd13, 7'd31, 7'd65, 7'd63,
                       7'd100, 7'd64};
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed grids at the reset width: single row, all walls, a band, stripes.
      send_row('1, 1'b1);
      for (int r = 0; r < 5; r++) send_row('1, r == 4);
      send_row('0, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('0, 1'b1);
      send_row(64'h5555_5555_5555_5555, 1'b0);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_row(64'hFFFF_0000_FFFF_0000, 1'b0);
      send_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
      send_row(64'hCCCC_CCCC_CCCC_CCCC, 1'b0);
      send_row(64'h3333_3333_3333_3333, 1'b1);
      // Narrow grid, empty width, oversize width, and a width change inside a grid.
      write_width(7'd4);
      send_grid(3, 2, 1'b0);
      write_width(7'd0);
      send_grid(2, 0, 1'b0);
      write_width(7'd127);
      send_row(make_row(5), 1'b0);
      write_width(7'd9);
      send_grid(3, 3, 1'b0);

      for (int phase = 0; phase < 12; phase++) begin
         write_width(phase_widths[phase]);
         quiet = (phase == 2) || ($urandom_range(0, 3) == 0);
         if (phase == 2) hold_request = 1'b1;
         in_phase = 0;
         while (in_phase < PHASE_ROWS) begin
            rows = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            send_grid(rows, $urandom_range(0, 5), $urandom_range(0, 9) == 0);
            in_phase += rows;
            if ($urandom_range(0, 15) == 0) wait_idle();
         end
      end
      quiet = 1'b0;

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Covered %0d input rows, %0d output rows checked, %0d width writes.",
               rows_sent, rows_checked, widths_used);
      $display("Included narrow, empty and oversize widths, noisy last_row and %0d long holds.",
               long_holds);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
